>>> src/vtgd_pkg.sv
`default_nettype none

package vtgd_pkg;

    // Width of the running cursor and path start; coordinates wrap at this width.
    localparam int COORD_BITS = 32;
    localparam int WORD_BITS = 32;
    localparam int COUNT_BITS = 30;
    localparam int ID_BITS = 3;
    localparam int EXTENT_BITS = 17;
    localparam int OUT_BITS = 16;
    // Compare width for the inside test, wide enough for both the coordinate and the limit.
    localparam int CMP_BITS = (COORD_BITS > EXTENT_BITS) ? COORD_BITS : EXTENT_BITS;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = 17'd4096;
    localparam logic [EXTENT_BITS-1:0] EXTENT_CAP = 17'd65536;

    // Command ids carried in the low bits of a command word.
    localparam logic [ID_BITS-1:0] CMD_NONE = 3'd0;
    localparam logic [ID_BITS-1:0] CMD_MOVE = 3'd1;
    localparam logic [ID_BITS-1:0] CMD_LINE = 3'd2;
    localparam logic [ID_BITS-1:0] CMD_CLOSE = 3'd7;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_MOVE,
        OP_LINE,
        OP_CLOSE
    } op_kind_t;

    // One classified operation passed from the front end to the back end.
    typedef struct packed {
        op_kind_t             kind;
        logic                 clear;
        logic [WORD_BITS-1:0] dx;
        logic [WORD_BITS-1:0] dy;
    } op_t;

    function automatic logic [WORD_BITS-1:0] unzig(input logic [WORD_BITS-1:0] w);
        return (w >> 1) ^ {WORD_BITS{w[0]}};
    endfunction

    function automatic coord_t widen(input logic [WORD_BITS-1:0] d);
        logic signed [WORD_BITS-1:0] s;
        s = d;
        return COORD_BITS'(s);
    endfunction

    function automatic logic coord_in_tile(input coord_t c,
                                           input logic [EXTENT_BITS-1:0] lim);
        logic [CMP_BITS-1:0] cw;
        logic [CMP_BITS-1:0] lw;
        cw = CMP_BITS'(c);
        lw = CMP_BITS'(lim);
        return !c[COORD_BITS-1] && (c != '0) && (cw < lw);
    endfunction

endpackage

`default_nettype wire

>>> src/vtgd_front.sv
`default_nettype none

module vtgd_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          accept,
    input  wire logic [vtgd_pkg::WORD_BITS-1:0] word,
    input  wire logic                          new_feature,
    output vtgd_pkg::op_t                      op,
    output logic                               op_push
);

    logic [vtgd_pkg::ID_BITS-1:0]    cmd_id_reg, cmd_id_next;
    logic [vtgd_pkg::COUNT_BITS-1:0] left_reg, left_next;
    logic                            half_reg, half_next;
    logic [vtgd_pkg::WORD_BITS-1:0]  held_reg, held_next;

    logic [vtgd_pkg::ID_BITS-1:0]    cmd_eff;
    logic [vtgd_pkg::COUNT_BITS-1:0] left_eff;
    logic                            half_eff;
    logic [vtgd_pkg::WORD_BITS-1:0]  held_eff;
    vtgd_pkg::op_kind_t              kind;

    always_comb begin
        // A new feature clears the command state before this word is looked at.
        cmd_eff  = new_feature ? vtgd_pkg::CMD_NONE : cmd_id_reg;
        left_eff = new_feature ? '0 : left_reg;
        half_eff = new_feature ? 1'b0 : half_reg;
        held_eff = new_feature ? '0 : held_reg;

        cmd_id_next = cmd_eff;
        left_next   = left_eff;
        half_next   = half_eff;
        held_next   = held_eff;
        kind        = vtgd_pkg::OP_NONE;

        if (left_eff == '0) begin
            cmd_id_next = word[vtgd_pkg::ID_BITS-1:0];
            half_next   = 1'b0;
            if (word[vtgd_pkg::ID_BITS-1:0] == vtgd_pkg::CMD_MOVE ||
                word[vtgd_pkg::ID_BITS-1:0] == vtgd_pkg::CMD_LINE) begin
                left_next = {word[vtgd_pkg::WORD_BITS-1:vtgd_pkg::ID_BITS], 1'b0};
            end else begin
                left_next = '0;
            end
            if (word[vtgd_pkg::ID_BITS-1:0] == vtgd_pkg::CMD_CLOSE) begin
                kind = vtgd_pkg::OP_CLOSE;
            end
        end else begin
            left_next = left_eff - 1'b1;
            if (!half_eff) begin
                held_next = word;
                half_next = 1'b1;
            end else begin
                half_next = 1'b0;
                if (cmd_eff == vtgd_pkg::CMD_MOVE) begin
                    kind = vtgd_pkg::OP_MOVE;
                end else if (cmd_eff == vtgd_pkg::CMD_LINE) begin
                    kind = vtgd_pkg::OP_LINE;
                end
            end
        end
    end

    always_comb begin
        op.kind  = kind;
        op.clear = new_feature;
        op.dx    = vtgd_pkg::unzig(held_eff);
        op.dy    = vtgd_pkg::unzig(word);
        // Words that change nothing downstream are not queued.
        op_push  = accept && (kind != vtgd_pkg::OP_NONE || new_feature);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_id_reg <= vtgd_pkg::CMD_NONE;
            left_reg   <= '0;
            half_reg   <= 1'b0;
        end else if (accept) begin
            cmd_id_reg <= cmd_id_next;
            left_reg   <= left_next;
            half_reg   <= half_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

>>> src/vtgd_queue.sv
`default_nettype none

module vtgd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire vtgd_pkg::op_t push_op,
    output logic               full,
    input  wire logic          pop,
    output vtgd_pkg::op_t      head_op,
    output logic               head_valid
);

    vtgd_pkg::op_t                   entry_reg [vtgd_pkg::QUEUE_DEPTH];
    logic [vtgd_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [vtgd_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [vtgd_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                            do_push, do_pop;

    assign full       = (count_reg == vtgd_pkg::QCNT_BITS'(vtgd_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == vtgd_pkg::QPTR_BITS'(vtgd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == vtgd_pkg::QPTR_BITS'(vtgd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= vtgd_pkg::QCNT_BITS'(vtgd_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // An operation offered while the queue is full would be lost.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into a full queue");

    // A push into an empty queue shows up at the head on the next cycle.
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !head_valid) |=> head_valid)
        else $error("pushed entry not visible");

endmodule

`default_nettype wire

>>> src/vtgd_back.sv
`default_nettype none

module vtgd_back (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             q_valid,
    input  wire vtgd_pkg::op_t                    q_op,
    output logic                                  q_pop,
    input  wire logic [vtgd_pkg::EXTENT_BITS-1:0] extent,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [vtgd_pkg::OUT_BITS-1:0]         m_start_x,
    output logic [vtgd_pkg::OUT_BITS-1:0]         m_start_y,
    output logic [vtgd_pkg::OUT_BITS-1:0]         m_end_x,
    output logic [vtgd_pkg::OUT_BITS-1:0]         m_end_y,
    output logic                                  m_is_closing
);

    vtgd_pkg::coord_t cursor_x_reg, cursor_x_next;
    vtgd_pkg::coord_t cursor_y_reg, cursor_y_next;
    vtgd_pkg::coord_t path_x_reg, path_x_next;
    vtgd_pkg::coord_t path_y_reg, path_y_next;
    logic             m_valid_reg, m_valid_next;
    logic [vtgd_pkg::OUT_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic             closing_reg;

    vtgd_pkg::coord_t base_x, base_y, base_px, base_py, new_x, new_y;
    vtgd_pkg::coord_t sx, sy, ex, ey;
    logic             cand, closing, emit;
    logic [vtgd_pkg::EXTENT_BITS-1:0] lim;

    assign q_pop = q_valid && (!m_valid_reg || m_ready);
    assign lim   = (extent > vtgd_pkg::EXTENT_CAP) ? vtgd_pkg::EXTENT_CAP : extent;

    always_comb begin
        base_x  = q_op.clear ? '0 : cursor_x_reg;
        base_y  = q_op.clear ? '0 : cursor_y_reg;
        base_px = q_op.clear ? '0 : path_x_reg;
        base_py = q_op.clear ? '0 : path_y_reg;
        new_x   = base_x + vtgd_pkg::widen(q_op.dx);
        new_y   = base_y + vtgd_pkg::widen(q_op.dy);

        cursor_x_next = base_x;
        cursor_y_next = base_y;
        path_x_next   = base_px;
        path_y_next   = base_py;
        sx      = base_x;
        sy      = base_y;
        ex      = new_x;
        ey      = new_y;
        cand    = 1'b0;
        closing = 1'b0;

        unique case (q_op.kind)
            vtgd_pkg::OP_MOVE: begin
                cursor_x_next = new_x;
                cursor_y_next = new_y;
                path_x_next   = new_x;
                path_y_next   = new_y;
            end
            vtgd_pkg::OP_LINE: begin
                cursor_x_next = new_x;
                cursor_y_next = new_y;
                cand          = 1'b1;
            end
            vtgd_pkg::OP_CLOSE: begin
                ex      = base_px;
                ey      = base_py;
                cand    = 1'b1;
                closing = 1'b1;
            end
            vtgd_pkg::OP_NONE: begin
                cand = 1'b0;
            end
        endcase

        emit = cand &&
               vtgd_pkg::coord_in_tile(sx, lim) && vtgd_pkg::coord_in_tile(sy, lim) &&
               vtgd_pkg::coord_in_tile(ex, lim) && vtgd_pkg::coord_in_tile(ey, lim);

        if (q_pop) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            path_x_reg   <= '0;
            path_y_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (q_pop) begin
                cursor_x_reg <= cursor_x_next;
                cursor_y_reg <= cursor_y_next;
                path_x_reg   <= path_x_next;
                path_y_reg   <= path_y_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && emit) begin
            sx_reg      <= sx[vtgd_pkg::OUT_BITS-1:0];
            sy_reg      <= sy[vtgd_pkg::OUT_BITS-1:0];
            ex_reg      <= ex[vtgd_pkg::OUT_BITS-1:0];
            ey_reg      <= ey[vtgd_pkg::OUT_BITS-1:0];
            closing_reg <= closing;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_start_x    = sx_reg;
    assign m_start_y    = sy_reg;
    assign m_end_x      = ex_reg;
    assign m_end_y      = ey_reg;
    assign m_is_closing = closing_reg;

    // Every delivered segment has all endpoints strictly above zero.
    a_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (sx_reg != '0 && sy_reg != '0 && ex_reg != '0 && ey_reg != '0))
        else $error("segment endpoint on the tile edge");

    // A segment waiting at the output is never overwritten by a new operation.
    a_no_pop_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !q_pop)
        else $error("operation consumed while output stalled");

    // A closing segment can only come from a ClosePath operation.
    a_close_src: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && emit && closing) |-> (q_op.kind == vtgd_pkg::OP_CLOSE))
        else $error("closing flag on a non-close operation");

endmodule

`default_nettype wire

>>> src/vector_tile_geometry_decoder_unit.sv
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  geometry_word[31:0], new_feature
// m_        out        m_valid / m_ready  start_x, start_y, end_x, end_y [15:0], is_closing
// cfg_      in         cfg_we             cfg_wdata[16:0] (tile extent)
//
// One word is taken per cycle while the queue has room; the operation that completes
// a segment passes through the queue and the executor into the output register.
// The front end decodes commands and pairs parameters, a two-entry queue follows,
// and the executor does one cursor add and the extent test per cycle unless stalled.
// Synchronous active-low reset clears the command state, cursor, queue and output valid,
// and sets the tile extent to 4096. Output stalls fill the queue and then drop s_ready.

module vector_tile_geometry_decoder_unit (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [vtgd_pkg::WORD_BITS-1:0]        s_geometry_word,
    input  wire logic                                  s_new_feature,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [vtgd_pkg::OUT_BITS-1:0]              m_start_x,
    output logic [vtgd_pkg::OUT_BITS-1:0]              m_start_y,
    output logic [vtgd_pkg::OUT_BITS-1:0]              m_end_x,
    output logic [vtgd_pkg::OUT_BITS-1:0]              m_end_y,
    output logic                                       m_is_closing,
    input  wire logic                                  cfg_we,
    input  wire logic [vtgd_pkg::EXTENT_BITS-1:0]      cfg_wdata
);

    // The tile extent register. The user must write it only while the block is idle, so
    // operations in flight always see one consistent value; the block does not enforce it.
    logic [vtgd_pkg::EXTENT_BITS-1:0] extent_reg;

    logic          accept;
    logic          q_full;
    logic          op_push;
    vtgd_pkg::op_t front_op;
    vtgd_pkg::op_t head_op;
    logic          head_valid;
    logic          q_pop;

    // A word is taken whenever the queue has room; the front end never blocks on
    // its own, because every word is decoded in the cycle it arrives.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            extent_reg <= vtgd_pkg::EXTENT_RESET;
        end else if (cfg_we) begin
            extent_reg <= cfg_wdata;
        end
    end

    // Front end: command decode, parameter counting and dx/dy pairing.
    vtgd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .word        (s_geometry_word),
        .new_feature (s_new_feature),
        .op          (front_op),
        .op_push     (op_push)
    );

    // Short queue that decouples the decoder from output back-pressure.
    vtgd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (op_push),
        .push_op    (front_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_op    (head_op),
        .head_valid (head_valid)
    );

    // Back end: cursor and path-start tracking, extent test and output register.
    vtgd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (head_valid),
        .q_op         (head_op),
        .q_pop        (q_pop),
        .extent       (extent_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_start_x    (m_start_x),
        .m_start_y    (m_start_y),
        .m_end_x      (m_end_x),
        .m_end_y      (m_end_y),
        .m_is_closing (m_is_closing)
    );

endmodule

`default_nettype wire

>>> tb/vector_tile_geometry_decoder_unit_tb.sv
`default_nettype none

module vector_tile_geometry_decoder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef vtgd_pkg::coord_t coord_t;
    localparam int COORD_BITS = vtgd_pkg::COORD_BITS;
    localparam int WORD_BITS = vtgd_pkg::WORD_BITS;
    localparam int OUT_BITS = vtgd_pkg::OUT_BITS;
    localparam int EXTENT_BITS = vtgd_pkg::EXTENT_BITS;
    localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = vtgd_pkg::EXTENT_RESET;
    localparam logic [2:0] CMD_NONE = vtgd_pkg::CMD_NONE;
    localparam logic [2:0] CMD_MOVE = vtgd_pkg::CMD_MOVE;
    localparam logic [2:0] CMD_LINE = vtgd_pkg::CMD_LINE;
    localparam logic [2:0] CMD_CLOSE = vtgd_pkg::CMD_CLOSE;

    // The package names only the ids the block acts on. The rest are ignored by the
    // decoder, but the stimulus still has to reach every one of them.
    localparam logic [2:0] CMD_UNUSED3 = 3'd3;
    localparam logic [2:0] CMD_UNUSED4 = 3'd4;
    localparam logic [2:0] CMD_UNUSED5 = 3'd5;
    localparam logic [2:0] CMD_UNUSED6 = 3'd6;

    localparam logic [EXTENT_BITS-1:0] EXTENT_CAP_VALUE = 17'd65536;
    localparam logic [28:0] COUNT_MAX = 29'h1FFF_FFFF;

    // The operation of the word that completes a segment is registered in the queue and
    // then in the output register, and the internal queue holds two operations, so
    // SETTLE_CYCLES covers any word that is still in flight but produces no segment.
    localparam int SETTLE_CYCLES = 8;
    // Longest legal stretch without any handshake is the forced receiver hold-off below.
    localparam int PRESSURE_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 185;

    typedef struct packed {
        logic [OUT_BITS-1:0] sx;
        logic [OUT_BITS-1:0] sy;
        logic [OUT_BITS-1:0] ex;
        logic [OUT_BITS-1:0] ey;
        logic                closing;
    } segment_t;

    // How the expectation for one stimulus row is obtained.
    typedef enum {BY_PREDICTOR, NO_SEGMENT, TYPED_SEGMENT} row_check_t;

    typedef struct {
        logic [WORD_BITS-1:0] word;
        logic                 new_feature;
        row_check_t           check;
        segment_t             seg;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [WORD_BITS-1:0]   s_geometry_word = '0;
    logic                   s_new_feature = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_BITS-1:0]    m_start_x;
    logic [OUT_BITS-1:0]    m_start_y;
    logic [OUT_BITS-1:0]    m_end_x;
    logic [OUT_BITS-1:0]    m_end_y;
    logic                   m_is_closing;
    logic                   cfg_we = 1'b0;
    logic [EXTENT_BITS-1:0] cfg_wdata = '0;

    vector_tile_geometry_decoder_unit dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_geometry_word (s_geometry_word),
        .s_new_feature   (s_new_feature),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_x       (m_start_x),
        .m_start_y       (m_start_y),
        .m_end_x         (m_end_x),
        .m_end_y         (m_end_y),
        .m_is_closing    (m_is_closing),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------------
    // Predictor state. This is the testbench's own copy of the decoder: the command
    // being executed, how many parameter words it still owes, the held x delta of a
    // half-filled pair, the running cursor and the start of the current path.
    // ------------------------------------------------------------------------------
    logic [EXTENT_BITS-1:0] tile_extent_now;
    logic [2:0]             active_cmd;
    logic [29:0]            params_owed;
    logic                   have_dx;
    logic [WORD_BITS-1:0]   held_dx;
    coord_t                 cur_x, cur_y, path_x, path_y;

    segment_t expected_segments[$];
    stim_row_t word_batch[$];
    segment_t oldest;

    int words_accepted = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit pressure_armed = 1'b0;
    bit pressure_done = 1'b0;

    // Directed part. Rows with a typed expectation are the ones whose outcome is plain
    // from the numbers: parameters are zigzag coded, so 20 means +10, 5 means -3 and
    // 8188 means +4094. All of it runs at the reset extent of 4096.
    localparam int DIRECTED_ROWS = 27;
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // Closing straight after reset: cursor and path start are both the origin.
        '{{29'd0, CMD_CLOSE}, 1'b0, NO_SEGMENT, '0},
        // Move to (10, 20), which also becomes the path start.
        '{{29'd1, CMD_MOVE}, 1'b1, NO_SEGMENT, '0},
        '{32'd20, 1'b0, NO_SEGMENT, '0},
        '{32'd40, 1'b0, NO_SEGMENT, '0},
        // Line by (+5, -3) to (15, 17).
        '{{29'd1, CMD_LINE}, 1'b0, NO_SEGMENT, '0},
        '{32'd10, 1'b0, NO_SEGMENT, '0},
        '{32'd5, 1'b0, TYPED_SEGMENT, '{16'd10, 16'd20, 16'd15, 16'd17, 1'b0}},
        // Close back to the path start, then again with the largest repeat count:
        // a close gives one segment however large its count is.
        '{{29'd0, CMD_CLOSE}, 1'b0, TYPED_SEGMENT, '{16'd15, 16'd17, 16'd10, 16'd20, 1'b1}},
        '{{COUNT_MAX, CMD_CLOSE}, 1'b0, TYPED_SEGMENT,
          '{16'd15, 16'd17, 16'd10, 16'd20, 1'b1}},
        // Unknown ids take no parameters, even with a huge count.
        '{{29'd0, CMD_NONE}, 1'b0, NO_SEGMENT, '0},
        '{{COUNT_MAX, CMD_UNUSED3}, 1'b0, NO_SEGMENT, '0},
        '{{29'd0, CMD_UNUSED4}, 1'b0, NO_SEGMENT, '0},
        '{{29'd2, CMD_UNUSED5}, 1'b0, NO_SEGMENT, '0},
        '{{29'd0, CMD_UNUSED6}, 1'b0, NO_SEGMENT, '0},
        // A line with a zero count owes nothing; the next word is a command again.
        '{{29'd0, CMD_LINE}, 1'b0, NO_SEGMENT, '0},
        // Largest positive x delta and most negative y delta: the cursor wraps negative.
        '{{29'd1, CMD_LINE}, 1'b0, NO_SEGMENT, '0},
        '{32'hFFFF_FFFE, 1'b0, NO_SEGMENT, '0},
        '{32'hFFFF_FFFF, 1'b0, BY_PREDICTOR, '0},
        // New feature, move to (1, 1), then line to (4095, 4095): both corners inside.
        '{{29'd1, CMD_MOVE}, 1'b1, NO_SEGMENT, '0},
        '{32'd2, 1'b0, NO_SEGMENT, '0},
        '{32'd2, 1'b0, NO_SEGMENT, '0},
        '{{29'd1, CMD_LINE}, 1'b0, NO_SEGMENT, '0},
        '{32'd8188, 1'b0, NO_SEGMENT, '0},
        '{32'd8188, 1'b0, TYPED_SEGMENT, '{16'd1, 16'd1, 16'd4095, 16'd4095, 1'b0}},
        // A new feature in the middle of a pair drops the pair and the cursor.
        '{{29'd2, CMD_LINE}, 1'b0, NO_SEGMENT, '0},
        '{32'd8, 1'b0, NO_SEGMENT, '0},
        '{{29'd0, CMD_CLOSE}, 1'b1, NO_SEGMENT, '0}
    };

    // ------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------
    function automatic void clear_cursor();
        active_cmd = CMD_NONE;
        params_owed = '0;
        have_dx = 1'b0;
        held_dx = '0;
        cur_x = '0;
        cur_y = '0;
        path_x = '0;
        path_y = '0;
    endfunction

    // Zigzag parameter to a signed delta, sign extended to the cursor width.
    function automatic coord_t zigzag_delta(input logic [WORD_BITS-1:0] w);
        logic signed [WORD_BITS-1:0] v;
        v = (w >> 1) ^ {WORD_BITS{w[0]}};
        return coord_t'(v);
    endfunction

    // A coordinate counts as on the tile when it is positive and below the extent,
    // with extents above 65536 clipped so that every emitted value fits 16 bits.
    function automatic bit on_tile(input coord_t c);
        logic [EXTENT_BITS-1:0] lim;
        lim = (tile_extent_now > EXTENT_CAP_VALUE) ? EXTENT_CAP_VALUE : tile_extent_now;
        return !c[COORD_BITS-1] && (c != '0) && (c < coord_t'(lim));
    endfunction

    function automatic bit bounded_segment(input coord_t sx, input coord_t sy,
                                           input coord_t ex, input coord_t ey,
                                           input logic closing, output segment_t seg);
        seg = '{sx[OUT_BITS-1:0], sy[OUT_BITS-1:0], ex[OUT_BITS-1:0], ey[OUT_BITS-1:0],
                closing};
        return on_tile(sx) && on_tile(sy) && on_tile(ex) && on_tile(ey);
    endfunction

    // Advances the predictor by one accepted word; returns 1 when a segment results.
    function automatic bit predict_segment(input logic [WORD_BITS-1:0] word,
                                           input logic new_feature,
                                           output segment_t seg);
        coord_t old_x, old_y;
        seg = '0;
        if (new_feature) begin
            clear_cursor();
        end
        if (params_owed == '0) begin
            active_cmd = word[2:0];
            have_dx = 1'b0;
            if (active_cmd == CMD_MOVE || active_cmd == CMD_LINE) begin
                params_owed = {word[WORD_BITS-1:3], 1'b0};
            end else begin
                params_owed = '0;
            end
            if (active_cmd == CMD_CLOSE) begin
                return bounded_segment(cur_x, cur_y, path_x, path_y, 1'b1, seg);
            end
            return 1'b0;
        end
        params_owed = params_owed - 30'd1;
        if (!have_dx) begin
            held_dx = word;
            have_dx = 1'b1;
            return 1'b0;
        end
        have_dx = 1'b0;
        old_x = cur_x;
        old_y = cur_y;
        cur_x = cur_x + zigzag_delta(held_dx);
        cur_y = cur_y + zigzag_delta(word);
        if (active_cmd == CMD_MOVE) begin
            path_x = cur_x;
            path_y = cur_y;
            return 1'b0;
        end
        if (active_cmd == CMD_LINE) begin
            return bounded_segment(old_x, old_y, cur_x, cur_y, 1'b0, seg);
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------------
    // Sender. Valid is raised at a rising edge and held with a steady payload until
    // the edge at which ready is seen high. The predictor runs at that same edge, so
    // the expectation is queued long before the segment can leave the block.
    // ------------------------------------------------------------------------------
    task automatic send_word(input stim_row_t row);
        segment_t seg;
        bit made;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_geometry_word <= row.word;
        s_new_feature <= row.new_feature;
        do @(posedge aclk); while (!s_ready);
        words_accepted++;
        made = predict_segment(row.word, row.new_feature, seg);
        case (row.check)
            BY_PREDICTOR: begin
                if (made) begin
                    expected_segments.insert(expected_segments.size(), seg);
                end
            end
            TYPED_SEGMENT: begin
                expected_segments.insert(expected_segments.size(), row.seg);
            end
            default: begin
            end
        endcase
    endtask

    // Drops valid and waits until every expected segment is out and any word that
    // gives no segment has passed through the pipeline too.
    task automatic drain_block();
        s_valid <= 1'b0;
        while (expected_segments.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------------
    // Stimulus generation. A feature starts with a new-feature word and a MoveTo, then
    // a few random paths built from MoveTo, LineTo and ClosePath. The generator tracks
    // its own cursor so that it can aim points at the tile, its edges, or far outside.
    // ------------------------------------------------------------------------------
    function automatic logic [WORD_BITS-1:0] zigzag_code(input logic [WORD_BITS-1:0] d);
        return {d[WORD_BITS-2:0], 1'b0} ^ {WORD_BITS{d[WORD_BITS-1]}};
    endfunction

    function automatic logic [WORD_BITS-1:0] next_coord(input logic [WORD_BITS-1:0] cur,
                                                        input int lim);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (lim < 2) begin
                    return $urandom_range(0, 2);
                end
                return $urandom_range(1, lim - 1);
            end
            5, 6: return cur + $urandom_range(0, 8) - 4;
            7: return lim - 1;
            8: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return 32'd1;
                    default: return lim;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic void push_word(input logic [WORD_BITS-1:0] w, input logic nf);
        word_batch.insert(word_batch.size(), stim_row_t'{w, nf, BY_PREDICTOR, '0});
    endfunction

    function automatic void push_point(inout logic [WORD_BITS-1:0] gx,
                                       inout logic [WORD_BITS-1:0] gy, input int lim);
        logic [WORD_BITS-1:0] tx, ty;
        tx = next_coord(gx, lim);
        ty = next_coord(gy, lim);
        push_word(zigzag_code(tx - gx), 1'b0);
        push_word(zigzag_code(ty - gy), 1'b0);
        gx = tx;
        gy = ty;
    endfunction

    function automatic void build_feature();
        logic [WORD_BITS-1:0] gx, gy;
        int lim;
        int n;
        if (tile_extent_now == '0) begin
            lim = 4096;
        end else if (tile_extent_now > EXTENT_CAP_VALUE) begin
            lim = 65536;
        end else begin
            lim = int'(tile_extent_now);
        end
        gx = '0;
        gy = '0;
        push_word({29'd1, CMD_MOVE}, 1'b1);
        push_point(gx, gy, lim);
        repeat ($urandom_range(1, 4)) begin
            n = $urandom_range(1, 6);
            case ($urandom_range(0, 9))
                0, 1: begin
                    push_word({29'(n), CMD_MOVE}, 1'b0);
                    repeat (n) push_point(gx, gy, lim);
                end
                8, 9: begin
                    if ($urandom_range(0, 7) == 0) begin
                        push_word({29'($urandom()), CMD_CLOSE}, 1'b0);
                    end else begin
                        push_word({29'($urandom_range(0, 3)), CMD_CLOSE}, 1'b0);
                    end
                end
                default: begin
                    push_word({29'(n), CMD_LINE}, 1'b0);
                    repeat (n) push_point(gx, gy, lim);
                end
            endcase
        end
        // Now and then cut the feature short so that a pair or a count is left open
        // when the next feature starts.
        if ($urandom_range(0, 19) == 0) begin
            void'(word_batch.pop_back());
        end
    endfunction

    // Noise: raw 32-bit words, many of them unknown commands, some starting a feature.
    function automatic void build_noise();
        logic [WORD_BITS-1:0] w;
        repeat ($urandom_range(1, 4)) begin
            w = $urandom();
            case ($urandom_range(0, 6))
                0: w[2:0] = CMD_NONE;
                1: w[2:0] = CMD_UNUSED3;
                2: w[2:0] = CMD_UNUSED4;
                3: w[2:0] = CMD_UNUSED5;
                4: w[2:0] = CMD_UNUSED6;
                default: begin
                end
            endcase
            push_word(w, $urandom_range(0, 3) == 0);
        end
    endfunction

    // ------------------------------------------------------------------------------
    // Receiver. Ready is redrawn at every edge from the current idle rate. Once armed,
    // it holds ready low for a long stretch so that the queue fills and the block
    // stops taking words while the sender keeps offering them.
    // ------------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (pressure_armed && !pressure_done) begin
            m_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge aclk);
            pressure_done = 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic check_field(input string name, input logic [OUT_BITS-1:0] want,
                               input logic [OUT_BITS-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Every segment the block hands over is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_segments.size() == 0) begin
                $error("segment (%0d,%0d)->(%0d,%0d) closing %0b with none expected",
                       m_start_x, m_start_y, m_end_x, m_end_y, m_is_closing);
                mismatch_count++;
            end else begin
                oldest = expected_segments.pop_front();
                check_field("start_x", oldest.sx, m_start_x);
                check_field("start_y", oldest.sy, m_start_y);
                check_field("end_x", oldest.ex, m_end_x);
                check_field("end_y", oldest.ey, m_end_y);
                check_field("is_closing", {15'd0, oldest.closing}, {15'd0, m_is_closing});
            end
        end
    end

    // Watchdog: a stretch with no word moving on either channel far longer than the
    // forced hold-off means the block has hung or lost a segment.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random phases. Each phase sets a
    // new extent while the block is idle and picks how the two sides stall: first
    // the sender idles lightly and the receiver heavily, then the other way round,
    // then neither stalls (with the long receiver hold-off in the first such phase).
    // ------------------------------------------------------------------------------
    initial begin
        logic [EXTENT_BITS-1:0] extent_value;
        int phase_end;
        tile_extent_now = EXTENT_RESET;
        clear_cursor();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 17;
        recv_idle_pct = 86;
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i]);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: extent_value = EXTENT_RESET;
                1: extent_value = 17'd1;
                2: extent_value = EXTENT_CAP_VALUE;
                3: extent_value = '1;
                4: extent_value = '0;
                5: extent_value = EXTENT_BITS'($urandom_range(2, 300));
                6: extent_value = EXTENT_BITS'($urandom_range(1, 65536));
                default: extent_value = EXTENT_BITS'($urandom());
            endcase
            drain_block();
            // The register only changes while nothing is in flight.
            cfg_we <= 1'b1;
            cfg_wdata <= extent_value;
            @(posedge aclk);
            cfg_we <= 1'b0;
            tile_extent_now = extent_value;

            if (p < 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 86;
            end else if (p < 6) begin
                send_idle_pct = 86;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 6) begin
                pressure_armed = 1'b1;
            end

            phase_end = words_accepted + WORDS_PER_PHASE;
            while (words_accepted < phase_end) begin
                word_batch.delete();
                if ($urandom_range(0, 99) < 15) begin
                    build_noise();
                end else begin
                    build_feature();
                end
                foreach (word_batch[i]) begin
                    send_word(word_batch[i]);
                end
            end
        end

        drain_block();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
src/vtgd_pkg.sv
src/vtgd_front.sv
src/vtgd_queue.sv
src/vtgd_back.sv
src/vector_tile_geometry_decoder_unit.sv
tb/vector_tile_geometry_decoder_unit_tb.sv
